FILE: rtl/efb_pkg.sv
// ----------------------------------------------------------------------------
// efb_pkg
// Shared types, sizes and codes for the escaped frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package efb_pkg;

  localparam int BUF_BYTES  = 512;
  localparam int ADDR_W     = $clog2(BUF_BYTES);
  localparam int POS_W      = ADDR_W + 1;
  localparam int DATA_BYTES = 8;
  localparam int DATA_W     = 8 * DATA_BYTES;
  localparam int LEN_W      = 4;
  localparam int RADDR_W    = 9;
  localparam int OUT_LEN_W  = 10;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_PARAM = 2'd1,
    OP_END   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic [1:0] CFG_CONTROL     = 2'd0;
  localparam logic [1:0] CFG_FRAME_START = 2'd1;
  localparam logic [1:0] CFG_FRAME_END   = 2'd2;
  localparam logic [1:0] CFG_PARAM_START = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN0,
    ST_BEGIN1,
    ST_PHDR,
    ST_PDATA,
    ST_PDUP,
    ST_END_CALC,
    ST_MOVE,
    ST_LEN,
    ST_XOR,
    ST_TAIL,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [7:0] control_code;
    logic [7:0] frame_start_code;
    logic [7:0] frame_end_code;
    logic [7:0] param_start_code;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         param_type;
    logic [7:0]         param_index;
    logic [LEN_W-1:0]   data_len;
    logic [DATA_W-1:0]  data;
    logic [RADDR_W-1:0] read_address;
  } item_t;

  typedef struct packed {
    logic [7:0]           read_data;
    logic [OUT_LEN_W-1:0] frame_length;
    logic                 overflow;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic load;
    logic shift8;
    logic shift16;
  } shf_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/escaped_frame_builder_xor.sv
// ----------------------------------------------------------------------------
// escaped_frame_builder_xor
// Byte-stuffed frame builder with XOR checksum, streaming in and out.
// ----------------------------------------------------------------------------
// One transaction is handled at a time, and every byte moves through a
// single-port-per-direction byte store, one access per cycle. A read
// fetches one stored byte, a begin writes the control and start codes, a
// parameter writes its four header bytes and then each data byte, twice
// where it equals the control code, and an end moves the payload up when a
// length byte equals the control code, writes the length bytes, sweeps the
// frame for the checksum and appends the trailer. A new transaction is
// taken as soon as the previous one has reached the output register.
`default_nettype none

module escaped_frame_builder_xor (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // param_type[7:0], param_index[15:8], data_len[19:16], data[83:20],
  // read_address[92:84], zero fill[95:93]
  input  wire  [95:0] in_tdata,
  // operation[1:0]
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // read_data[7:0], frame_length[17:8], overflow[18], zero fill[23:19]
  output logic [23:0] out_tdata
);
  import efb_pkg::*;

  cfg_t      cfg_r;
  item_t     item;
  result_t   result;
  mem_req_t  mem_req;
  shf_ctl_t  shf_ctl;
  logic [7:0] mem_rdata;
  logic [7:0] shf_byte;
  logic      res_valid;
  logic      res_ready;
  logic      out_valid_r;
  result_t   out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_code     <= 8'd16;
      cfg_r.frame_start_code <= 8'd2;
      cfg_r.frame_end_code   <= 8'd3;
      cfg_r.param_start_code <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTROL:     cfg_r.control_code     <= cfg_wdata;
        CFG_FRAME_START: cfg_r.frame_start_code <= cfg_wdata;
        CFG_FRAME_END:   cfg_r.frame_end_code   <= cfg_wdata;
        CFG_PARAM_START: cfg_r.param_start_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign item.op           = op_t'(in_tuser);
  assign item.param_type   = in_tdata[7:0];
  assign item.param_index  = in_tdata[15:8];
  assign item.data_len     = in_tdata[19:16];
  assign item.data         = in_tdata[83:20];
  assign item.read_address = in_tdata[92:84];

  efb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .shf_ctl   (shf_ctl),
    .shf_byte  (shf_byte)
  );

  efb_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  efb_shifter u_shifter (
    .clk       (clk),
    .ctl       (shf_ctl),
    .load_data (item.data),
    .top_byte  (shf_byte)
  );

  // Output register: a finished result waits here while new work starts.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_res_r.overflow, out_res_r.frame_length,
                       out_res_r.read_data};

endmodule

`default_nettype wire

FILE: rtl/efb_store.sv
// ----------------------------------------------------------------------------
// efb_store
// Frame byte store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module efb_store (
  input  wire                clk,
  input  efb_pkg::mem_req_t  mem_req,
  output logic [7:0]         rdata
);
  import efb_pkg::*;

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata_r <= mem[mem_req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/efb_shifter.sv
// ----------------------------------------------------------------------------
// efb_shifter
// Byte-serial shift register that hands out parameter data, top byte first.
// ----------------------------------------------------------------------------
`default_nettype none

module efb_shifter (
  input  wire                          clk,
  input  efb_pkg::shf_ctl_t            ctl,
  input  wire [efb_pkg::DATA_W-1:0]    load_data,
  output logic [7:0]                   top_byte
);
  import efb_pkg::*;

  logic [DATA_W-1:0] sh_r;

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      sh_r <= load_data;
    end else if (ctl.shift16) begin
      sh_r <= {sh_r[DATA_W-17:0], 16'h0000};
    end else if (ctl.shift8) begin
      sh_r <= {sh_r[DATA_W-9:0], 8'h00};
    end
  end

  assign top_byte = sh_r[DATA_W-1 -: 8];

endmodule

`default_nettype wire

FILE: rtl/efb_ctrl.sv
// ----------------------------------------------------------------------------
// efb_ctrl
// Sequencer: writes frame bytes one per cycle, shifts the payload for a
// stuffed length, and sweeps the store for the checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module efb_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  efb_pkg::cfg_t       cfg,
  input  wire                 in_valid,
  output logic                in_ready,
  input  efb_pkg::item_t      item,
  output logic                res_valid,
  input  wire                 res_ready,
  output efb_pkg::result_t    result,
  output efb_pkg::mem_req_t   mem_req,
  input  wire [7:0]           mem_rdata,
  output efb_pkg::shf_ctl_t   shf_ctl,
  input  wire [7:0]           shf_byte
);
  import efb_pkg::*;

  st_t               state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              ovf_r, ovf_nxt;
  logic              pend_r, pend_nxt;
  op_t               op_r, op_nxt;
  logic [7:0]        ptype_r, ptype_nxt;
  logic [7:0]        pindex_r, pindex_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  align_r, align_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [RADDR_W-1:0] raddr_r, raddr_nxt;
  logic [7:0]        rd_r, rd_nxt;
  logic [1:0]        shift_r, shift_nxt;
  logic              dup_hi_r, dup_hi_nxt;
  logic [7:0]        lenhi_r, lenhi_nxt;
  logic [7:0]        lenlo_r, lenlo_nxt;
  logic [POS_W-1:0]  mv_cnt_r, mv_cnt_nxt;
  logic [ADDR_W-1:0] mv_src_r, mv_src_nxt;
  logic [ADDR_W-1:0] pend_dst_r, pend_dst_nxt;
  logic [POS_W-1:0]  x_addr_r, x_addr_nxt;
  logic [7:0]        xor_r, xor_nxt;

  logic              put_en;
  logic [7:0]        put_byte;

  always_comb begin
    logic [7:0]       hi;
    logic [7:0]       lo;
    logic             dh;
    logic             dl;
    logic [1:0]       sh;
    logic [POS_W:0]   need;
    logic [POS_W-1:0] keep;
    logic [LEN_W-1:0] len_c;
    logic             rd_ok;

    state_nxt    = state_r;
    pos_nxt      = pos_r;
    ovf_nxt      = ovf_r;
    pend_nxt     = pend_r;
    op_nxt       = op_r;
    ptype_nxt    = ptype_r;
    pindex_nxt   = pindex_r;
    rem_nxt      = rem_r;
    align_nxt    = align_r;
    cnt_nxt      = cnt_r;
    raddr_nxt    = raddr_r;
    rd_nxt       = rd_r;
    shift_nxt    = shift_r;
    dup_hi_nxt   = dup_hi_r;
    lenhi_nxt    = lenhi_r;
    lenlo_nxt    = lenlo_r;
    mv_cnt_nxt   = mv_cnt_r;
    mv_src_nxt   = mv_src_r;
    pend_dst_nxt = pend_dst_r;
    x_addr_nxt   = x_addr_r;
    xor_nxt      = xor_r;
    mem_req      = '0;
    shf_ctl      = '0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    put_en       = 1'b0;
    put_byte     = 8'h00;

    // Length bytes and the room they need in front of the payload.
    hi   = 8'(pos_r >> 8);
    lo   = pos_r[7:0];
    dh   = (hi == cfg.control_code);
    dl   = (lo == cfg.control_code);
    sh   = {1'b0, dh} + {1'b0, dl};
    need = {1'b0, pos_r} + (POS_W+1)'(sh);
    if (need > (POS_W+1)'(BUF_BYTES)) begin
      keep = POS_W'(BUF_BYTES - 4) - POS_W'(sh);
    end else begin
      keep = pos_r - POS_W'(4);
    end
    len_c = (item.data_len > LEN_W'(DATA_BYTES)) ? LEN_W'(DATA_BYTES) : item.data_len;
    rd_ok = (32'(raddr_r) < BUF_BYTES);

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt        = item.op;
          ptype_nxt     = item.param_type;
          pindex_nxt    = item.param_index;
          raddr_nxt     = item.read_address;
          rem_nxt       = len_c;
          align_nxt     = LEN_W'(DATA_BYTES) - len_c;
          cnt_nxt       = 2'd0;
          rd_nxt        = 8'h00;
          shf_ctl.load  = 1'b1;
          unique case (item.op)
            OP_BEGIN: state_nxt = ST_BEGIN0;
            OP_PARAM: state_nxt = ST_PHDR;
            OP_END:   state_nxt = (pos_r < POS_W'(4)) ? ST_BEGIN0 : ST_END_CALC;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_BEGIN0: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(0);
        mem_req.wdata = cfg.control_code;
        ovf_nxt       = 1'b0;
        state_nxt     = ST_BEGIN1;
      end
      ST_BEGIN1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(1);
        mem_req.wdata = cfg.frame_start_code;
        pos_nxt       = POS_W'(4);
        state_nxt     = (op_r == OP_END) ? ST_END_CALC : ST_DONE;
      end
      ST_PHDR: begin
        put_en = 1'b1;
        unique case (cnt_r)
          2'd0:    put_byte = cfg.control_code;
          2'd1:    put_byte = cfg.param_start_code;
          2'd2:    put_byte = ptype_r;
          default: put_byte = pindex_r;
        endcase
        // The data word is brought to the top of the shifter meanwhile.
        if (align_r >= LEN_W'(2)) begin
          shf_ctl.shift16 = 1'b1;
          align_nxt       = align_r - LEN_W'(2);
        end else if (align_r == LEN_W'(1)) begin
          shf_ctl.shift8 = 1'b1;
          align_nxt      = LEN_W'(0);
        end
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_PDATA;
        end
      end
      ST_PDATA: begin
        if (rem_r == LEN_W'(0)) begin
          state_nxt = ST_DONE;
        end else begin
          put_en   = 1'b1;
          put_byte = shf_byte;
          if (shf_byte == cfg.control_code) begin
            state_nxt = ST_PDUP;
          end else begin
            shf_ctl.shift8 = 1'b1;
            rem_nxt        = rem_r - LEN_W'(1);
          end
        end
      end
      ST_PDUP: begin
        put_en         = 1'b1;
        put_byte       = shf_byte;
        shf_ctl.shift8 = 1'b1;
        rem_nxt        = rem_r - LEN_W'(1);
        state_nxt      = ST_PDATA;
      end
      ST_END_CALC: begin
        lenhi_nxt  = hi;
        lenlo_nxt  = lo;
        dup_hi_nxt = dh;
        shift_nxt  = sh;
        cnt_nxt    = 2'd0;
        if (sh == 2'd0) begin
          state_nxt = ST_LEN;
        end else begin
          if (need > (POS_W+1)'(BUF_BYTES)) begin
            ovf_nxt = 1'b1;
          end
          pos_nxt    = POS_W'(4) + POS_W'(sh) + keep;
          mv_cnt_nxt = keep;
          mv_src_nxt = ADDR_W'(keep + POS_W'(3));
          pend_nxt   = 1'b0;
          state_nxt  = ST_MOVE;
        end
      end
      ST_MOVE: begin
        // Top-down copy: read one byte, write it shift places higher next cycle.
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_dst_r;
          mem_req.wdata = mem_rdata;
        end
        pend_nxt = 1'b0;
        if (mv_cnt_r != POS_W'(0)) begin
          mem_req.re   = 1'b1;
          mem_req.raddr = mv_src_r;
          pend_nxt     = 1'b1;
          pend_dst_nxt = mv_src_r + ADDR_W'(shift_r);
          mv_src_nxt   = mv_src_r - ADDR_W'(1);
          mv_cnt_nxt   = mv_cnt_r - POS_W'(1);
        end else if (!pend_r) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(2) + ADDR_W'(cnt_r);
        mem_req.wdata = ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && dup_hi_r)) ? lenhi_r : lenlo_r;
        cnt_nxt       = cnt_r + 2'd1;
        if (cnt_r == shift_r + 2'd1) begin
          x_addr_nxt = POS_W'(0);
          xor_nxt    = 8'h00;
          pend_nxt   = 1'b0;
          state_nxt  = ST_XOR;
        end
      end
      ST_XOR: begin
        if (pend_r) begin
          xor_nxt = xor_r ^ mem_rdata;
        end
        pend_nxt = 1'b0;
        if (x_addr_r < pos_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = x_addr_r[ADDR_W-1:0];
          pend_nxt      = 1'b1;
          x_addr_nxt    = x_addr_r + POS_W'(1);
        end else if (!pend_r) begin
          cnt_nxt   = 2'd0;
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        put_en = 1'b1;
        unique case (cnt_r)
          2'd0:    put_byte = cfg.control_code;
          2'd1:    put_byte = cfg.frame_end_code;
          2'd2:    put_byte = xor_r;
          default: put_byte = 8'h00;
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        mem_req.re    = rd_ok;
        mem_req.raddr = ADDR_W'(raddr_r);
        state_nxt     = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        rd_nxt    = rd_ok ? mem_rdata : 8'h00;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // A byte appended at the write position; at capacity it is dropped.
    if (put_en) begin
      if (pos_r < POS_W'(BUF_BYTES)) begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r[ADDR_W-1:0];
        mem_req.wdata = put_byte;
        pos_nxt       = pos_r + POS_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      ovf_r   <= 1'b0;
      pend_r  <= 1'b0;
      xor_r   <= 8'h00;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ptype_r    <= ptype_nxt;
    pindex_r   <= pindex_nxt;
    rem_r      <= rem_nxt;
    align_r    <= align_nxt;
    cnt_r      <= cnt_nxt;
    raddr_r    <= raddr_nxt;
    rd_r       <= rd_nxt;
    shift_r    <= shift_nxt;
    dup_hi_r   <= dup_hi_nxt;
    lenhi_r    <= lenhi_nxt;
    lenlo_r    <= lenlo_nxt;
    mv_cnt_r   <= mv_cnt_nxt;
    mv_src_r   <= mv_src_nxt;
    pend_dst_r <= pend_dst_nxt;
    x_addr_r   <= x_addr_nxt;
  end

  assign result.read_data    = rd_r;
  assign result.frame_length = OUT_LEN_W'(pos_r);
  assign result.overflow     = ovf_r;

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(BUF_BYTES))
    else $error("write position beyond store capacity");

  a_begin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BEGIN1) |=> (pos_r == POS_W'(4)) && !ovf_r)
    else $error("frame begin did not leave position four and a clear flag");

  a_xor_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_XOR) |-> !mem_req.we)
    else $error("store written during checksum sweep");

  a_ovf_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> (($past(pos_r) == POS_W'(BUF_BYTES)) ||
                      ($past(state_r) == ST_END_CALC)))
    else $error("overflow raised without a full store");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not start work");

endmodule

`default_nettype wire

FILE: verif/escaped_frame_builder_xor_tb.sv
// ----------------------------------------------------------------------------
// escaped_frame_builder_xor_tb
// Self-checking bench for the byte-stuffed frame builder with XOR checksum.
// A scoreboard keeps its own copy of the frame store and predicts each result:
// a directed run covers field extremes, control bytes in the data, lengths
// that need a length byte doubled and an end without a begin, then random
// frames, noise and reads run under several marker settings.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_builder_xor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efb_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;

  class frame_checker;
    bit [7:0]    store [BUF_BYTES];
    bit          written [BUF_BYTES];
    int unsigned wpos;
    bit [7:0]    xsum;
    bit          ovf;
    bit [7:0]    ctrl, start_code, end_code, pstart_code;
    result_t     expected_results [$];
    int          errors;

    function new();
      wpos        = 0;
      xsum        = '0;
      ovf         = 1'b0;
      ctrl        = 8'd16;
      start_code  = 8'd2;
      end_code    = 8'd3;
      pstart_code = 8'd4;
      errors      = 0;
    endfunction

    function void set_codes(bit [7:0] c, bit [7:0] s, bit [7:0] e, bit [7:0] p);
      ctrl        = c;
      start_code  = s;
      end_code    = e;
      pstart_code = p;
    endfunction

    function void put_byte(bit [7:0] b);
      if (wpos < BUF_BYTES) begin
        store[wpos]   = b;
        written[wpos] = 1'b1;
        wpos++;
      end else begin
        wpos = BUF_BYTES;
        ovf  = 1'b1;
      end
    endfunction

    function void begin_frame();
      ovf  = 1'b0;
      wpos = 0;
      put_byte(ctrl);
      put_byte(start_code);
      wpos = 4;
    endfunction

    function void add_param(item_t it);
      int unsigned n;
      bit [7:0]    b;
      put_byte(ctrl);
      put_byte(pstart_code);
      put_byte(it.param_type);
      put_byte(it.param_index);
      n = (it.data_len > 8) ? 8 : it.data_len;
      for (int i = 0; i < n; i++) begin
        b = it.data >> (8 * (n - 1 - i));
        put_byte(b);
        if (b == ctrl) put_byte(b);
      end
    endfunction

    function void end_frame();
      bit [7:0]    lenb [4];
      int unsigned cnt, shift, payload, keep, len;
      bit [7:0]    hi, lo, x;
      if (wpos < 4) begin_frame();
      len = wpos;
      hi  = len >> 8;
      lo  = len;
      cnt = 0;
      lenb[cnt++] = hi;
      if (hi == ctrl) lenb[cnt++] = hi;
      lenb[cnt++] = lo;
      if (lo == ctrl) lenb[cnt++] = lo;
      shift = cnt - 2;
      if (shift > 0) begin
        payload = wpos - 4;
        keep    = payload;
        if (4 + shift + payload > BUF_BYTES) begin
          keep = BUF_BYTES - 4 - shift;
          ovf  = 1'b1;
        end
        // Move from the top down so that the overlapping copy stays intact.
        for (int i = keep; i > 0; i--) begin
          store[4 + shift + i - 1]   = store[4 + i - 1];
          written[4 + shift + i - 1] = 1'b1;
        end
        wpos = 4 + shift + keep;
      end
      for (int i = 0; i < cnt; i++) begin
        store[2 + i]   = lenb[i];
        written[2 + i] = 1'b1;
      end
      x = '0;
      for (int i = 0; i < wpos; i++) x ^= store[i];
      xsum = x;
      put_byte(ctrl);
      put_byte(end_code);
      put_byte(xsum);
      put_byte(8'h00);
    endfunction

    function void note_item(item_t it);
      result_t r;
      r = '0;
      case (it.op)
        OP_BEGIN: begin_frame();
        OP_PARAM: add_param(it);
        OP_END:   end_frame();
        default: begin
          if (it.read_address < BUF_BYTES) r.read_data = store[it.read_address];
        end
      endcase
      r.frame_length = OUT_LEN_W'(wpos);
      r.overflow     = ovf;
      expected_results.push_back(r);
    endfunction

    function void check_result(bit [7:0] rd, bit [OUT_LEN_W-1:0] flen, bit ov);
      result_t e;
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: read_data %0h frame_length %0d overflow %0b",
               rd, flen, ov);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (rd != e.read_data) begin
        $error("read_data: expected %0h, got %0h", e.read_data, rd);
        errors++;
      end
      if (flen != e.frame_length) begin
        $error("frame_length: expected %0d, got %0d", e.frame_length, flen);
        errors++;
      end
      if (ov != e.overflow) begin
        $error("overflow: expected %0b, got %0b", e.overflow, ov);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [7:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  frame_checker sb = new();
  int           sent = 0;
  bit           sender_steady = 1'b0;
  bit           sink_steady = 1'b0;
  bit           hold_req = 1'b0;
  longint       cycles = 0;

  escaped_frame_builder_xor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Both handshakes are sampled on the edge, before this edge's updates land.
  always @(posedge clk) begin
    item_t it;
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[7:0], out_tdata[17:8], out_tdata[18]);
    if (rst_n && in_tvalid && in_tready) begin
      it.op           = op_t'(in_tuser);
      it.param_type   = in_tdata[7:0];
      it.param_index  = in_tdata[15:8];
      it.data_len     = in_tdata[19:16];
      it.data         = in_tdata[83:20];
      it.read_address = in_tdata[92:84];
      sb.note_item(it);
    end
  end

  // Result side back-pressure, including the long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = 300;
      end else if (stall == 0 && !sink_steady && $urandom_range(0, 5) == 0) begin
        stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(15, 60);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit [63:0] make_data(bit plain);
    bit [63:0] d;
    bit [7:0]  b;
    int        r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 7);
      if (!plain && r < 2) b = sb.ctrl;
      else if (r == 2)     b = 8'h00;
      else if (r == 3)     b = 8'hff;
      else                 b = $urandom_range(0, 255);
      if (plain && b == sb.ctrl) b = ~b;
      d[8*i +: 8] = b;
    end
    return d;
  endfunction

  // Only entries the frame store has actually received are ever read back.
  function automatic int pick_read_addr();
    int a, top;
    top = (sb.wpos == 0) ? 1 : ((sb.wpos > BUF_BYTES) ? BUF_BYTES : sb.wpos);
    for (int t = 0; t < 16; t++) begin
      if (t == 0 && $urandom_range(0, 7) == 0) a = BUF_BYTES - 1;
      else if (t < 8)                          a = $urandom_range(0, top - 1);
      else                                     a = $urandom_range(0, BUF_BYTES - 1);
      if (sb.written[a]) return a;
    end
    for (int i = 0; i < BUF_BYTES; i++)
      if (sb.written[i]) return i;
    return -1;
  endfunction

  task automatic send_op(op_t op, bit [7:0] ptype, bit [7:0] pidx, bit [3:0] dlen,
                         bit [63:0] data, bit [8:0] raddr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, raddr, data, dlen, pidx, ptype};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_ctl(op_t op);
    send_op(op, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 15),
            {$urandom, $urandom}, $urandom_range(0, 511));
  endtask

  task automatic send_read();
    int a;
    a = pick_read_addr();
    if (a >= 0)
      send_op(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 15), {$urandom, $urandom}, a[8:0]);
  endtask

  task automatic send_param(bit [3:0] dlen, bit plain);
    bit [7:0] pt, pi;
    pt = ($urandom_range(0, 7) == 0) ? {8{$urandom_range(0, 1) == 1}} : $urandom_range(0, 255);
    pi = ($urandom_range(0, 7) == 0) ? {8{$urandom_range(0, 1) == 1}} : $urandom_range(0, 255);
    send_op(OP_PARAM, pt, pi, dlen, make_data(plain), $urandom_range(0, 511));
  endtask

  task automatic send_random_param();
    bit [3:0] dlen;
    dlen = ($urandom_range(0, 15) < 13) ? $urandom_range(0, 8) : $urandom_range(9, 15);
    send_param(dlen, 1'b0);
  endtask

  task automatic send_noise();
    op_t op;
    op = op_t'($urandom_range(0, 3));
    if (op == OP_READ) send_read();
    else if (op == OP_PARAM) send_random_param();
    else send_ctl(op);
  endtask

  // Builds a frame whose unstuffed length before the end is exactly target.
  task automatic send_sized_frame(int unsigned target);
    int unsigned rest;
    send_ctl(OP_BEGIN);
    rest = target - 4;
    while (rest > 0) begin
      if (rest > 15 || rest == 12) begin
        send_param(4'd8, 1'b1);
        rest -= 12;
      end else if (rest > 12) begin
        send_param(rest - 8, 1'b1);
        rest = 4;
      end else begin
        send_param(rest - 4, 1'b1);
        rest = 0;
      end
    end
    send_ctl(OP_END);
  endtask

  task automatic random_frame();
    int k;
    if ($urandom_range(0, 9) == 0) send_noise();
    if ($urandom_range(0, 11) != 0) send_ctl(OP_BEGIN);
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 45) : $urandom_range(0, 6);
    repeat (k) send_random_param();
    if ($urandom_range(0, 11) != 0) send_ctl(OP_END);
    repeat ($urandom_range(0, 3)) send_read();
  endtask

  // Lowers valid, lets every pending result drain and the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_codes(bit [7:0] c, bit [7:0] s, bit [7:0] e, bit [7:0] p);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CONTROL;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_index <= CFG_FRAME_START;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= CFG_FRAME_END;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_index <= CFG_PARAM_START;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_codes(c, s, e, p);
  endtask

  initial begin
    bit [7:0]    codes [8][4];
    int unsigned sized [8];
    int          start;
    codes[0] = '{8'd16, 8'd2, 8'd3, 8'd4};
    codes[1] = '{8'h00, 8'hff, 8'h00, 8'hff};
    codes[2] = '{8'hff, 8'h00, 8'hff, 8'h00};
    codes[3] = '{8'h02, 8'h07, 8'h09, 8'h0b};
    codes[4] = '{8'h01, 8'h02, 8'h03, 8'h04};
    for (int i = 5; i < 8; i++)
      codes[i] = '{($urandom_range(0, 1) == 1) ? $urandom_range(0, 255) : $urandom_range(0, 2),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)};
    // Lengths whose high or low byte matches that phase's control code.
    sized = '{272, 100, 255, 512, 257, 0, 0, 0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // An end with no frame open starts one of its own.
    send_ctl(OP_END);
    send_op(OP_READ, 8'h00, 8'h00, 4'h0, 64'h0, 9'd0);
    send_op(OP_READ, 8'hff, 8'hff, 4'hf, '1, 9'd7);
    send_ctl(OP_BEGIN);
    send_op(OP_PARAM, 8'h00, 8'hff, 4'd0, 64'h0, 9'd0);
    send_op(OP_PARAM, 8'hff, 8'h00, 4'd8, '1, 9'h1ff);
    send_op(OP_PARAM, 8'h5a, 8'h01, 4'd8, {8{8'h10}}, 9'd0);
    send_op(OP_PARAM, 8'h10, 8'h10, 4'd15, 64'h0123_4510_89ab_cdef, 9'd0);
    send_op(OP_PARAM, 8'h81, 8'h7e, 4'd3, 64'h0, 9'd0);
    send_ctl(OP_END);
    send_op(OP_READ, 8'h00, 8'h00, 4'h0, 64'h0, 9'd2);
    send_op(OP_READ, 8'h00, 8'h00, 4'h0, 64'h0, 9'd3);
    send_read();
    // A sixteen-byte frame doubles the low length byte at the default code.
    send_sized_frame(16);
    send_op(OP_READ, 8'h00, 8'h00, 4'h0, 64'h0, 9'd4);
    send_read();

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_codes(codes[ph][0], codes[ph][1], codes[ph][2], codes[ph][3]);
      start         = sent;
      sender_steady = (ph == 5);
      sink_steady   = (ph == 5);
      if (sized[ph] != 0) send_sized_frame(sized[ph]);
      if (ph == 2) begin
        // Keep offering while the result side is held off for a long stretch.
        hold_req      = 1'b1;
        sender_steady = 1'b1;
        repeat (4) send_random_param();
        send_ctl(OP_END);
        repeat (3) send_read();
        sender_steady = 1'b0;
      end
      while (sent - start < 95) begin
        random_frame();
        if ($urandom_range(0, 4) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
